### rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; included by files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define SLED_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: assertion failed");

// Property checked on every clock edge, reset included.
`define SLED_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("%m: assertion failed");

`endif

### rtl/sled_pkg.sv
// Types, codes and helpers for the string literal escape decoder.
// Depends on nothing; used by every module of the block.
package sled_pkg;

    // Most hex digits allowed inside \x{...}
    localparam logic [3:0] MAX_BRACE_DIGITS = 4'd8;

    // Result kinds
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [3:0] ERR_NONE         = 4'd0;
    localparam logic [3:0] ERR_NO_ESCAPE    = 4'd1;
    localparam logic [3:0] ERR_SHORT_U      = 4'd2;
    localparam logic [3:0] ERR_NONHEX_U     = 4'd3;
    localparam logic [3:0] ERR_SHORT_X      = 4'd4;
    localparam logic [3:0] ERR_NONHEX_X     = 4'd5;
    localparam logic [3:0] ERR_EMPTY_BRACES = 4'd6;
    localparam logic [3:0] ERR_NO_BRACE_END = 4'd7;
    localparam logic [3:0] ERR_TOO_MANY     = 4'd8;
    localparam logic [3:0] ERR_BAD_ESCAPE   = 4'd9;
    localparam logic [3:0] ERR_NO_QUOTE     = 4'd10;

    // Character codes
    localparam logic [20:0] CH_BACKSLASH = 21'h5C;
    localparam logic [20:0] CH_DQUOTE    = 21'h22;
    localparam logic [20:0] CH_SQUOTE    = 21'h27;
    localparam logic [20:0] CH_LC_N      = 21'h6E;
    localparam logic [20:0] CH_LC_T      = 21'h74;
    localparam logic [20:0] CH_LC_V      = 21'h76;
    localparam logic [20:0] CH_LC_B      = 21'h62;
    localparam logic [20:0] CH_LC_R      = 21'h72;
    localparam logic [20:0] CH_LC_F      = 21'h66;
    localparam logic [20:0] CH_LC_A      = 21'h61;
    localparam logic [20:0] CH_ZERO      = 21'h30;
    localparam logic [20:0] CH_NINE      = 21'h39;
    localparam logic [20:0] CH_UC_A      = 21'h41;
    localparam logic [20:0] CH_UC_F      = 21'h46;
    localparam logic [20:0] CH_LC_U      = 21'h75;
    localparam logic [20:0] CH_UC_U      = 21'h55;
    localparam logic [20:0] CH_LC_X      = 21'h78;
    localparam logic [20:0] CH_LBRACE    = 21'h7B;
    localparam logic [20:0] CH_RBRACE    = 21'h7D;

    // Decoded values of the simple escapes
    localparam logic [31:0] VAL_NL  = 32'd10;
    localparam logic [31:0] VAL_TAB = 32'd9;
    localparam logic [31:0] VAL_VT  = 32'd11;
    localparam logic [31:0] VAL_BS  = 32'd8;
    localparam logic [31:0] VAL_CR  = 32'd13;
    localparam logic [31:0] VAL_FF  = 32'd12;
    localparam logic [31:0] VAL_BEL = 32'd7;
    localparam logic [31:0] VAL_NUL = 32'd0;

    // Decoder modes
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_BODY,
        MODE_ESC,
        MODE_HEX,
        MODE_XFIRST,
        MODE_XSECOND,
        MODE_BRACE
    } mode_t;

    // Input word
    typedef struct packed {
        logic [20:0] code_point;
        logic        first;
        logic        last;
    } in_t;

    // Result word
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] char_value;
        logic [3:0]  error_code;
    } out_t;

    // Decoder state carried between words
    typedef struct packed {
        mode_t       mode;
        logic [3:0]  digits_left;
        logic [31:0] accumulator;
    } state_t;

    // Hex digit decode: {is_hex, value}
    function automatic logic [4:0] hex_decode(logic [20:0] c);
        logic [4:0] r;
        r = 5'd0;
        case (c) inside
            [CH_ZERO:CH_NINE]: r = {1'b1, c[3:0]};
            [CH_UC_A:CH_UC_F],
            [CH_LC_A:CH_LC_F]: r = {1'b1, c[3:0] + 4'd9};
            default:           r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

### rtl/sled_step.sv
// One decode step: next state and optional result for one input word.
// Depends on sled_pkg.
module sled_step (
    input  sled_pkg::in_t    in_word,
    input  sled_pkg::state_t cur,
    output sled_pkg::state_t nxt,
    output logic             res_valid,
    output sled_pkg::out_t   res
);

    logic [4:0]  hex;
    logic        is_hex;
    logic [3:0]  hval;
    logic [20:0] c;
    logic        last;
    logic [31:0] acc_shift;
    logic [3:0]  dl_dec;

    assign c         = in_word.code_point;
    assign last      = in_word.last;
    assign hex       = sled_pkg::hex_decode(in_word.code_point);
    assign is_hex    = hex[4];
    assign hval      = hex[3:0];
    assign acc_shift = {cur.accumulator[27:0], hval};
    assign dl_dec    = cur.digits_left - 4'd1;

    always_comb begin
        logic        do_fail;
        logic        do_done;
        logic        do_deliver;
        logic [3:0]  ferr;
        logic [31:0] dval;

        nxt        = cur;
        do_fail    = 1'b0;
        do_done    = 1'b0;
        do_deliver = 1'b0;
        ferr       = sled_pkg::ERR_NONE;
        dval       = '0;

        // Mode update
        if (in_word.first) begin
            nxt.mode        = sled_pkg::MODE_BODY;
            nxt.digits_left = '0;
            nxt.accumulator = '0;
            if (last) begin
                do_fail = 1'b1;
                ferr    = sled_pkg::ERR_NO_QUOTE;
            end
        end else begin
            case (cur.mode)
                sled_pkg::MODE_BODY: begin
                    if (c == sled_pkg::CH_BACKSLASH) begin
                        if (last) begin
                            do_fail = 1'b1;
                            ferr    = sled_pkg::ERR_NO_ESCAPE;
                        end else begin
                            nxt.mode = sled_pkg::MODE_ESC;
                        end
                    end else if (c == sled_pkg::CH_DQUOTE) begin
                        do_done = 1'b1;
                    end else begin
                        do_deliver = 1'b1;
                        dval       = {11'd0, c};
                    end
                end

                sled_pkg::MODE_ESC: begin
                    case (c)
                        sled_pkg::CH_LC_N: begin
                            do_deliver = 1'b1; dval = sled_pkg::VAL_NL;
                        end
                        sled_pkg::CH_LC_T: begin
                            do_deliver = 1'b1; dval = sled_pkg::VAL_TAB;
                        end
                        sled_pkg::CH_LC_V: begin
                            do_deliver = 1'b1; dval = sled_pkg::VAL_VT;
                        end
                        sled_pkg::CH_LC_B: begin
                            do_deliver = 1'b1; dval = sled_pkg::VAL_BS;
                        end
                        sled_pkg::CH_LC_R: begin
                            do_deliver = 1'b1; dval = sled_pkg::VAL_CR;
                        end
                        sled_pkg::CH_LC_F: begin
                            do_deliver = 1'b1; dval = sled_pkg::VAL_FF;
                        end
                        sled_pkg::CH_LC_A: begin
                            do_deliver = 1'b1; dval = sled_pkg::VAL_BEL;
                        end
                        sled_pkg::CH_ZERO: begin
                            do_deliver = 1'b1; dval = sled_pkg::VAL_NUL;
                        end
                        sled_pkg::CH_BACKSLASH, sled_pkg::CH_SQUOTE,
                        sled_pkg::CH_DQUOTE: begin
                            do_deliver = 1'b1; dval = {11'd0, c};
                        end
                        sled_pkg::CH_LC_U, sled_pkg::CH_UC_U: begin
                            if (last) begin
                                do_fail = 1'b1;
                                ferr    = sled_pkg::ERR_SHORT_U;
                            end else begin
                                nxt.mode        = sled_pkg::MODE_HEX;
                                nxt.digits_left = (c == sled_pkg::CH_LC_U) ? 4'd4 : 4'd8;
                                nxt.accumulator = '0;
                            end
                        end
                        sled_pkg::CH_LC_X: begin
                            if (last) begin
                                do_fail = 1'b1;
                                ferr    = sled_pkg::ERR_SHORT_X;
                            end else begin
                                nxt.mode        = sled_pkg::MODE_XFIRST;
                                nxt.accumulator = '0;
                            end
                        end
                        default: begin
                            do_fail = 1'b1;
                            ferr    = sled_pkg::ERR_BAD_ESCAPE;
                        end
                    endcase
                end

                // Fixed-length \u / \U digits
                sled_pkg::MODE_HEX: begin
                    if (!is_hex) begin
                        do_fail = 1'b1;
                        ferr    = sled_pkg::ERR_NONHEX_U;
                    end else begin
                        nxt.accumulator = acc_shift;
                        nxt.digits_left = dl_dec;
                        if (dl_dec == 4'd0) begin
                            do_deliver = 1'b1;
                            dval       = acc_shift;
                        end else if (last) begin
                            do_fail = 1'b1;
                            ferr    = sled_pkg::ERR_SHORT_U;
                        end
                    end
                end

                sled_pkg::MODE_XFIRST: begin
                    if (c == sled_pkg::CH_LBRACE) begin
                        if (last) begin
                            do_fail = 1'b1;
                            ferr    = sled_pkg::ERR_NO_BRACE_END;
                        end else begin
                            nxt.mode        = sled_pkg::MODE_BRACE;
                            nxt.digits_left = sled_pkg::MAX_BRACE_DIGITS;
                            nxt.accumulator = '0;
                        end
                    end else if (!is_hex) begin
                        do_fail = 1'b1;
                        ferr    = sled_pkg::ERR_NONHEX_X;
                    end else if (last) begin
                        do_fail = 1'b1;
                        ferr    = sled_pkg::ERR_SHORT_X;
                    end else begin
                        nxt.accumulator = {28'd0, hval};
                        nxt.mode        = sled_pkg::MODE_XSECOND;
                    end
                end

                sled_pkg::MODE_XSECOND: begin
                    if (!is_hex) begin
                        do_fail = 1'b1;
                        ferr    = sled_pkg::ERR_NONHEX_X;
                    end else begin
                        do_deliver = 1'b1;
                        dval       = {24'd0, cur.accumulator[3:0], hval};
                    end
                end

                // \x{...} digits
                sled_pkg::MODE_BRACE: begin
                    if (!is_hex) begin
                        if (cur.digits_left == sled_pkg::MAX_BRACE_DIGITS) begin
                            do_fail = 1'b1;
                            ferr    = sled_pkg::ERR_EMPTY_BRACES;
                        end else if (c != sled_pkg::CH_RBRACE) begin
                            do_fail = 1'b1;
                            ferr    = sled_pkg::ERR_NO_BRACE_END;
                        end else begin
                            do_deliver = 1'b1;
                            dval       = cur.accumulator;
                        end
                    end else if (cur.digits_left == 4'd0) begin
                        do_fail = 1'b1;
                        ferr    = sled_pkg::ERR_TOO_MANY;
                    end else begin
                        nxt.accumulator = acc_shift;
                        nxt.digits_left = dl_dec;
                        if (last) begin
                            do_fail = 1'b1;
                            ferr    = sled_pkg::ERR_NO_BRACE_END;
                        end
                    end
                end

                default: begin
                    nxt.mode = sled_pkg::MODE_IDLE;
                end
            endcase
        end

        // Result forming; any done or error result returns to idle
        res_valid = 1'b0;
        res       = '0;
        if (do_fail || (do_deliver && last)) begin
            res_valid      = 1'b1;
            res.kind       = sled_pkg::KIND_ERROR;
            res.error_code = do_fail ? ferr : sled_pkg::ERR_NO_QUOTE;
            nxt.mode       = sled_pkg::MODE_IDLE;
        end else if (do_done) begin
            res_valid = 1'b1;
            res.kind  = sled_pkg::KIND_DONE;
            nxt.mode  = sled_pkg::MODE_IDLE;
        end else if (do_deliver) begin
            res_valid      = 1'b1;
            res.kind       = sled_pkg::KIND_CHAR;
            res.char_value = dval;
            nxt.mode       = sled_pkg::MODE_BODY;
        end
    end

endmodule

### rtl/string_literal_escape_decoder.sv
// String literal escape decoder: takes one code point per word, drops the opening
// quote, passes plain characters, decodes simple, \u, \U, \x and \x{...} escapes
// and ends on the closing quote with a done word, or with an error word carrying a
// code. It accepts one word every cycle while results are taken; a result word is
// registered: the accepting edge loads the input register, and the decode step is
// then loaded into the result register once the result side is free.
// A stalled result holds back only the input register, so one more word is taken
// before s_ready falls.
// Depends on sled_pkg and sled_step.
module string_literal_escape_decoder (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  sled_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output sled_pkg::out_t m_data
);

    logic             in_valid_reg;
    sled_pkg::in_t    in_word_reg;
    sled_pkg::state_t state_reg;
    sled_pkg::state_t state_next;
    logic             out_valid_reg;
    sled_pkg::out_t   out_word_reg;
    logic             res_valid;
    sled_pkg::out_t   res;
    logic             out_free;
    logic             advance;

    // Flow control
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;

    // Decode step
    sled_step u_step (
        .in_word   (in_word_reg),
        .cur       (state_reg),
        .nxt       (state_next),
        .res_valid (res_valid),
        .res       (res)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
    end

    // Decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode        <= sled_pkg::MODE_IDLE;
            state_reg.digits_left <= '0;
            state_reg.accumulator <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_word_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

endmodule

### rtl/sled_checker.sv
// Port-level checks for the string literal escape decoder, bound to the top level.
// Depends on sled_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sled_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input sled_pkg::out_t m_data
);

    logic out_stall;
    logic out_is_char;
    logic out_is_err;
    logic code_set;

    assign out_stall   = m_valid && !m_ready;
    assign out_is_char = (m_data.kind == sled_pkg::KIND_CHAR);
    assign out_is_err  = (m_data.kind == sled_pkg::KIND_ERROR);
    assign code_set    = (m_data.error_code != sled_pkg::ERR_NONE);

    // A stalled result word holds
    `SLED_ASSERT(a_out_hold, aclk, aresetn, out_stall |=> m_valid && $stable(m_data))

    // Only characters carry a value
    `SLED_ASSERT(a_value_zero, aclk, aresetn, m_valid && !out_is_char |-> m_data.char_value == 32'd0)

    // Errors carry a code, other words none
    `SLED_ASSERT(a_err_code, aclk, aresetn, m_valid |-> (out_is_err == code_set))

    // With the result side empty, input is never blocked
    `SLED_ASSERT(a_ready_empty, aclk, aresetn, !m_valid |-> s_ready)

    // Reset leaves no result pending
    `SLED_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> !m_valid)

endmodule

bind string_literal_escape_decoder sled_checker u_sled_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### verif/tb_string_literal_escape_decoder.sv
// Self-checking testbench for string_literal_escape_decoder: random and directed literals,
// a word-level decode predictor and an in-order result scoreboard.
// Depends on sled_pkg and the string_literal_escape_decoder RTL.
module tb_string_literal_escape_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import sled_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_CYCLES     = 60;
    localparam int WORDS_PER_PHASE = 325;
    localparam int TAIL_CYCLES     = 10;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    string_literal_escape_decoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // words waiting to be driven, words of the literal being built, predicted results
    in_t  word_q[$];
    in_t  build_q[$];
    out_t decoded_q[$];

    // predictor copy of the decoder state
    mode_t       dec_mode = MODE_IDLE;
    logic [3:0]  dec_left = '0;
    logic [31:0] dec_acc  = '0;

    int unsigned gap_pct    = 0;
    int unsigned stall_pct  = 0;
    bit          hold_req   = 1'b0;
    int          hold_left  = 0;
    bit          in_taken   = 1'b0;
    int          fail_count = 0;
    int          cycle_count = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // {is_hex, digit value}
    function automatic logic [4:0] hex_digit(logic [20:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return {1'b1, 4'(c - CH_ZERO)};
        if (c >= CH_UC_A && c <= CH_UC_F) return {1'b1, 4'(c - CH_UC_A + 21'd10)};
        if (c >= CH_LC_A && c <= CH_LC_F) return {1'b1, 4'(c - CH_LC_A + 21'd10)};
        return 5'd0;
    endfunction

    // done and error words close the literal
    function automatic void post_result(logic [1:0] k, logic [31:0] v, logic [3:0] e);
        out_t r;
        r.kind       = k;
        r.char_value = v;
        r.error_code = e;
        decoded_q.push_back(r);
        if (k != KIND_CHAR) dec_mode = MODE_IDLE;
    endfunction

    // a finished character cannot be kept once the text has ended
    function automatic void finish_char(logic [31:0] v, logic l);
        dec_mode = MODE_BODY;
        if (l) post_result(KIND_ERROR, '0, ERR_NO_QUOTE);
        else post_result(KIND_CHAR, v, ERR_NONE);
    endfunction

    function automatic void decode_word(in_t w);
        logic [20:0] c;
        logic        l;
        logic [4:0]  hx;
        c  = w.code_point;
        l  = w.last;
        hx = hex_digit(c);
        if (w.first) begin
            dec_mode = MODE_BODY;
            dec_left = '0;
            dec_acc  = '0;
            if (l) post_result(KIND_ERROR, '0, ERR_NO_QUOTE);
            return;
        end
        case (dec_mode)
            MODE_BODY: begin
                if (c == CH_BACKSLASH) begin
                    if (l) post_result(KIND_ERROR, '0, ERR_NO_ESCAPE);
                    else dec_mode = MODE_ESC;
                end else if (c == CH_DQUOTE) begin
                    post_result(KIND_DONE, '0, ERR_NONE);
                end else begin
                    finish_char({11'd0, c}, l);
                end
            end
            MODE_ESC: begin
                case (c)
                    CH_LC_N:      finish_char(VAL_NL, l);
                    CH_LC_T:      finish_char(VAL_TAB, l);
                    CH_LC_V:      finish_char(VAL_VT, l);
                    CH_LC_B:      finish_char(VAL_BS, l);
                    CH_LC_R:      finish_char(VAL_CR, l);
                    CH_LC_F:      finish_char(VAL_FF, l);
                    CH_LC_A:      finish_char(VAL_BEL, l);
                    CH_ZERO:      finish_char(VAL_NUL, l);
                    CH_BACKSLASH: finish_char({11'd0, CH_BACKSLASH}, l);
                    CH_SQUOTE:    finish_char({11'd0, CH_SQUOTE}, l);
                    CH_DQUOTE:    finish_char({11'd0, CH_DQUOTE}, l);
                    CH_LC_U, CH_UC_U: begin
                        if (l) begin
                            post_result(KIND_ERROR, '0, ERR_SHORT_U);
                        end else begin
                            dec_mode = MODE_HEX;
                            dec_left = (c == CH_LC_U) ? 4'd4 : 4'd8;
                            dec_acc  = '0;
                        end
                    end
                    CH_LC_X: begin
                        if (l) begin
                            post_result(KIND_ERROR, '0, ERR_SHORT_X);
                        end else begin
                            dec_mode = MODE_XFIRST;
                            dec_acc  = '0;
                        end
                    end
                    default: post_result(KIND_ERROR, '0, ERR_BAD_ESCAPE);
                endcase
            end
            MODE_HEX: begin
                if (!hx[4]) begin
                    post_result(KIND_ERROR, '0, ERR_NONHEX_U);
                end else begin
                    dec_acc  = {dec_acc[27:0], hx[3:0]};
                    dec_left = dec_left - 4'd1;
                    if (dec_left == 4'd0) finish_char(dec_acc, l);
                    else if (l) post_result(KIND_ERROR, '0, ERR_SHORT_U);
                end
            end
            MODE_XFIRST: begin
                if (c == CH_LBRACE) begin
                    if (l) begin
                        post_result(KIND_ERROR, '0, ERR_NO_BRACE_END);
                    end else begin
                        dec_mode = MODE_BRACE;
                        dec_left = MAX_BRACE_DIGITS;
                        dec_acc  = '0;
                    end
                end else if (!hx[4]) begin
                    post_result(KIND_ERROR, '0, ERR_NONHEX_X);
                end else if (l) begin
                    post_result(KIND_ERROR, '0, ERR_SHORT_X);
                end else begin
                    dec_acc  = {28'd0, hx[3:0]};
                    dec_mode = MODE_XSECOND;
                end
            end
            MODE_XSECOND: begin
                if (!hx[4]) post_result(KIND_ERROR, '0, ERR_NONHEX_X);
                else finish_char({24'd0, dec_acc[3:0], hx[3:0]}, l);
            end
            MODE_BRACE: begin
                if (!hx[4]) begin
                    if (dec_left == MAX_BRACE_DIGITS) post_result(KIND_ERROR, '0, ERR_EMPTY_BRACES);
                    else if (c != CH_RBRACE) post_result(KIND_ERROR, '0, ERR_NO_BRACE_END);
                    else finish_char(dec_acc, l);
                end else if (dec_left == 4'd0) begin
                    post_result(KIND_ERROR, '0, ERR_TOO_MANY);
                end else begin
                    dec_acc  = {dec_acc[27:0], hx[3:0]};
                    dec_left = dec_left - 4'd1;
                    if (l) post_result(KIND_ERROR, '0, ERR_NO_BRACE_END);
                end
            end
            default: ; // idle: words without an opening quote are dropped
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic logic [20:0] rand_any();
        if ($urandom_range(1)) return 21'($urandom_range(127));
        return 21'($urandom_range(21'h1FFFFF));
    endfunction

    function automatic logic [20:0] rand_plain();
        logic [20:0] c;
        do begin
            c = ($urandom_range(9) < 7) ? 21'($urandom_range(32, 126)) : rand_any();
        end while (c == CH_BACKSLASH || c == CH_DQUOTE);
        return c;
    endfunction

    function automatic logic [20:0] rand_hex();
        int r;
        r = $urandom_range(21);
        if (r < 10) return CH_ZERO + 21'(r);
        if (r < 16) return CH_UC_A + 21'(r - 10);
        return CH_LC_A + 21'(r - 16);
    endfunction

    function automatic logic [20:0] rand_nonhex();
        logic [20:0] c;
        logic [4:0]  hx;
        do begin
            c  = rand_any();
            hx = hex_digit(c);
        end while (hx[4]);
        return c;
    endfunction

    function automatic logic [20:0] simple_selector(int i);
        case (i)
            0:       return CH_LC_N;
            1:       return CH_LC_T;
            2:       return CH_LC_V;
            3:       return CH_LC_B;
            4:       return CH_LC_R;
            5:       return CH_LC_F;
            6:       return CH_LC_A;
            7:       return CH_ZERO;
            8:       return CH_BACKSLASH;
            9:       return CH_SQUOTE;
            default: return CH_DQUOTE;
        endcase
    endfunction

    task automatic stage(logic [20:0] cp, logic f, logic l);
        in_t w;
        w.code_point = cp;
        w.first      = f;
        w.last       = l;
        build_q.push_back(w);
    endtask

    task automatic stage_hex(int n);
        repeat (n) stage(rand_hex(), 1'b0, 1'b0);
    endtask

    // set the end-of-text flag on the newest staged word
    task automatic mark_end(logic l);
        in_t w;
        w      = build_q.pop_back();
        w.last = l;
        build_q.push_back(w);
    endtask

    task automatic flush_build();
        foreach (build_q[i]) word_q.push_back(build_q[i]);
        build_q.delete();
    endtask

    // one well-formed element: plain character or complete escape
    task automatic stage_element();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40) begin
            stage(rand_plain(), 1'b0, 1'b0);
        end else begin
            stage(CH_BACKSLASH, 1'b0, 1'b0);
            if (sel < 60) begin
                stage(simple_selector($urandom_range(10)), 1'b0, 1'b0);
            end else if (sel < 70) begin
                stage(CH_LC_U, 1'b0, 1'b0);
                stage_hex(4);
            end else if (sel < 77) begin
                stage(CH_UC_U, 1'b0, 1'b0);
                stage_hex(8);
            end else if (sel < 87) begin
                stage(CH_LC_X, 1'b0, 1'b0);
                stage_hex(2);
            end else begin
                stage(CH_LC_X, 1'b0, 1'b0);
                stage(CH_LBRACE, 1'b0, 1'b0);
                stage_hex($urandom_range(1, 8));
                stage(CH_RBRACE, 1'b0, 1'b0);
            end
        end
    endtask

    // one literal: opening quote, elements, then a close, an end of text,
    // a broken escape, or nothing (the next opening quote cuts in)
    task automatic gen_literal(inout int made);
        int          fate;
        int          n;
        bit          ok;
        logic [20:0] c;
        logic [20:0] u;
        build_q.delete();
        stage(($urandom_range(9) == 0) ? rand_any() : CH_DQUOTE, 1'b1, 1'b0);
        repeat ($urandom_range(6)) stage_element();
        u = $urandom_range(1) ? CH_LC_U : CH_UC_U;
        n = (u == CH_LC_U) ? 4 : 8;
        fate = $urandom_range(99);
        if (fate < 65) begin
            stage(CH_DQUOTE, 1'b0, 1'b0);
        end else if (fate < 70) begin
            stage(CH_DQUOTE, 1'b0, 1'b1);
        end else if (fate < 75) begin
            stage_element();
            mark_end(1'b1);
        end else if (fate < 93) begin
            case ($urandom_range(10))
                0: stage(CH_BACKSLASH, 1'b0, 1'b1);
                1: begin
                    stage(CH_BACKSLASH, 1'b0, 1'b0);
                    stage(u, 1'b0, 1'b0);
                    stage_hex($urandom_range(n - 1));
                    mark_end(1'b1);
                end
                2: begin
                    stage(CH_BACKSLASH, 1'b0, 1'b0);
                    stage(u, 1'b0, 1'b0);
                    stage_hex($urandom_range(n - 1));
                    stage(rand_nonhex(), 1'b0, 1'($urandom_range(1)));
                end
                3: begin
                    stage(CH_BACKSLASH, 1'b0, 1'b0);
                    stage(CH_LC_X, 1'b0, 1'b0);
                    stage_hex($urandom_range(1));
                    mark_end(1'b1);
                end
                4: begin
                    stage(CH_BACKSLASH, 1'b0, 1'b0);
                    stage(CH_LC_X, 1'b0, 1'b0);
                    stage_hex($urandom_range(1));
                    do c = rand_nonhex(); while (c == CH_LBRACE);
                    stage(c, 1'b0, 1'($urandom_range(1)));
                end
                5: begin
                    stage(CH_BACKSLASH, 1'b0, 1'b0);
                    stage(CH_LC_X, 1'b0, 1'b0);
                    stage(CH_LBRACE, 1'b0, 1'b0);
                    stage(CH_RBRACE, 1'b0, 1'($urandom_range(1)));
                end
                6: begin
                    stage(CH_BACKSLASH, 1'b0, 1'b0);
                    stage(CH_LC_X, 1'b0, 1'b0);
                    stage(CH_LBRACE, 1'b0, 1'b0);
                    stage_hex($urandom_range(1, 8));
                    do c = rand_nonhex(); while (c == CH_RBRACE);
                    stage(c, 1'b0, 1'($urandom_range(1)));
                end
                7: begin
                    stage(CH_BACKSLASH, 1'b0, 1'b0);
                    stage(CH_LC_X, 1'b0, 1'b0);
                    stage(CH_LBRACE, 1'b0, 1'b0);
                    stage_hex($urandom_range(8));
                    mark_end(1'b1);
                end
                8: begin
                    stage(CH_BACKSLASH, 1'b0, 1'b0);
                    stage(CH_LC_X, 1'b0, 1'b0);
                    stage(CH_LBRACE, 1'b0, 1'b0);
                    stage_hex(9);
                    mark_end(1'($urandom_range(1)));
                end
                9: begin
                    // selector that is no known escape
                    stage(CH_BACKSLASH, 1'b0, 1'b0);
                    do begin
                        c  = rand_any();
                        ok = !(c == CH_LC_U || c == CH_UC_U || c == CH_LC_X);
                        for (int i = 0; i < 11; i++) begin
                            if (c == simple_selector(i)) ok = 1'b0;
                        end
                    end while (!ok);
                    stage(c, 1'b0, 1'($urandom_range(1)));
                end
                default: stage(CH_DQUOTE, 1'b1, 1'b1);
            endcase
        end
        made += build_q.size();
        // stray words after the literal, mostly dropped by the block
        if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(1, 3)) stage(rand_any(), 1'b0, 1'($urandom_range(1)));
        end
        flush_build();
    endtask

    // wait until every staged word is taken and every predicted result has come
    task automatic drain();
        while (word_q.size() != 0 || s_valid) @(posedge aclk);
        while (decoded_q.size() != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    // ---------------------------------------------------------------
    // Input side: accept tracking, predictor and driver
    // ---------------------------------------------------------------

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            decode_word(s_data);
            in_taken = 1'b1;
        end
    end

    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_taken)) begin
            in_taken = 1'b0;
            if (word_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
                s_data  <= word_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result side: ready generation and checker
    // ---------------------------------------------------------------

    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (decoded_q.size() == 0) begin
                $error("unexpected result word: kind %0d char_value 0x%0h error_code %0d",
                       m_data.kind, m_data.char_value, m_data.error_code);
                fail_count++;
            end else begin
                want = decoded_q.pop_front();
                if (m_data.kind !== want.kind) begin
                    $error("kind: expected %0d, actual %0d", want.kind, m_data.kind);
                    fail_count++;
                end
                if (m_data.char_value !== want.char_value) begin
                    $error("char_value: expected 0x%0h, actual 0x%0h",
                           want.char_value, m_data.char_value);
                    fail_count++;
                end
                if (m_data.error_code !== want.error_code) begin
                    $error("error_code: expected %0d, actual %0d",
                           want.error_code, m_data.error_code);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Run control
    // ---------------------------------------------------------------

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int made;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, idle words, abandoned escape, end of text
        stage(21'h1FFFFF, 1'b0, 1'b1);          // dropped while idle
        stage(21'h0, 1'b1, 1'b0);               // opening quote with any code point
        stage(21'h1FFFFF, 1'b0, 1'b0);          // beyond Unicode, passed through
        stage(21'h0, 1'b0, 1'b0);
        stage(CH_BACKSLASH, 1'b0, 1'b0);
        stage(CH_LC_N, 1'b0, 1'b0);
        stage(CH_BACKSLASH, 1'b0, 1'b0);
        stage(CH_UC_U, 1'b0, 1'b0);
        repeat (4) begin
            stage(CH_UC_F, 1'b0, 1'b0);
            stage(CH_LC_F, 1'b0, 1'b0);
        end
        stage(CH_BACKSLASH, 1'b0, 1'b0);        // \x{} -> empty braces
        stage(CH_LC_X, 1'b0, 1'b0);
        stage(CH_LBRACE, 1'b0, 1'b0);
        stage(CH_RBRACE, 1'b0, 1'b0);
        stage(CH_DQUOTE, 1'b1, 1'b0);
        stage(CH_BACKSLASH, 1'b0, 1'b0);
        stage(CH_LC_X, 1'b0, 1'b0);
        stage(CH_ZERO + 21'd7, 1'b0, 1'b0);
        stage(CH_DQUOTE, 1'b1, 1'b0);           // new literal drops the open escape
        stage(CH_LC_A, 1'b0, 1'b1);             // text ends on a plain character
        stage(CH_DQUOTE, 1'b1, 1'b1);           // opening quote at end of text
        flush_build();
        drain();

        // random phases; each ends with the sender paused until all results are in
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 68; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 68; end
                default: begin gap_pct = 23; stall_pct = 23; end
            endcase
            made = 0;
            while (made < WORDS_PER_PHASE) gen_literal(made);
            // long receiver hold-off while the sender keeps offering
            if (phase == 0) hold_req = 1'b1;
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && decoded_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### string_literal_escape_decoder.f
+incdir+rtl
rtl/sled_pkg.sv
rtl/sled_step.sv
rtl/string_literal_escape_decoder.sv
rtl/sled_checker.sv
verif/tb_string_literal_escape_decoder.sv
